>>> sv/kpd_pkg.sv
// Shared types and constants for the keypad scan decoder with debounce.
package kpd_pkg;

  localparam int unsigned NibbleW   = 4;
  localparam int unsigned KeyCodeW  = 8;
  localparam int unsigned KeyIndexW = 4;
  localparam int unsigned MapWordW  = 64;
  localparam int unsigned CfgIndexW = 1;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] CfgKeyMapLow  = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgKeyMapHigh = 1'b1;

  typedef enum logic [1:0] {
    SCAN_NONE    = 2'd0,
    SCAN_VALID   = 2'd1,
    SCAN_INVALID = 2'd2
  } scan_status_t;

  typedef enum logic [1:0] {
    ST_RELEASED       = 2'd0,
    ST_MAYBE_PUSHED   = 2'd1,
    ST_PUSHED         = 2'd2,
    ST_MAYBE_RELEASED = 2'd3
  } deb_state_t;

  // Result of decoding one scan.
  typedef struct packed {
    scan_status_t            status;
    logic [KeyIndexW-1:0]    index;
  } scan_result_t;

endpackage

>>> sv/kpd_in_if.sv
// Valid/ready channel that carries one keypad scan item.
interface kpd_in_if import kpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NibbleW-1:0] row_lines;
  logic [NibbleW-1:0] column_lines;

  modport source (output valid, output row_lines, output column_lines, input ready);
  modport sink   (input valid, input row_lines, input column_lines, output ready);
endinterface

>>> sv/kpd_out_if.sv
// Valid/ready channel that carries one debounced keypad result item.
interface kpd_out_if import kpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KeyCodeW-1:0]  held_key;
  logic                 new_key;
  logic [1:0]           scan_status;
  logic [KeyIndexW-1:0] raw_index;

  modport source (output valid, output held_key, output new_key, output scan_status,
                  output raw_index, input ready);
  modport sink   (input valid, input held_key, input new_key, input scan_status,
                  input raw_index, output ready);
endinterface

>>> sv/matrix_keypad_decode_debounce.sv
// Top level of the 4x4 keypad scan decoder with debounce and key-code map.
//
// The in_ch channel takes one scan item per accepted handshake: the active-low
// row nibble and column nibble of the key matrix. The out_ch channel returns
// exactly one result item per scan: the held key code, a new-key flag, the raw
// scan status and the raw key index. Both channels use valid/ready; an item
// moves at a rising edge where both are high.
// The block has two register stages: a scan register and a result register.
// An accepted scan waits in the scan register until the result register is free,
// then moves there and is offered on out_ch; one scan can be accepted every cycle
// as long as the receiver takes results. When the receiver stalls, the result
// register holds its item, the scan register still takes one more scan, and
// only then does in_ch.ready drop.
// The debounce state advances when a scan moves into the result register, so
// scans are handled strictly in order.
// The user must write the key-code map via cfg_we, cfg_index and cfg_wdata only
// while the block is idle; the block does not enforce this. Synchronous reset
// (rst_n low) empties both stages, sets debounce released, clears latched key, maps.
module matrix_keypad_decode_debounce import kpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  kpd_in_if.sink                in_ch,
  kpd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CfgIndexW-1:0]  cfg_index,
  input  logic [MapWordW-1:0]   cfg_wdata
);

  // Configuration: two words that together hold sixteen 8-bit key codes.
  logic [MapWordW-1:0] key_map_low_r;
  logic [MapWordW-1:0] key_map_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_map_low_r  <= '0;
      key_map_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgKeyMapLow:  key_map_low_r  <= cfg_wdata;
        CfgKeyMapHigh: key_map_high_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Scan register stage.
  logic               s1_valid_r;
  logic [NibbleW-1:0] s1_rows_r;
  logic [NibbleW-1:0] s1_cols_r;
  logic               s1_advance;
  logic               in_fire;

  // Result register stage.
  logic                 out_valid_r;
  logic [KeyCodeW-1:0]  held_key_r;
  logic                 new_key_r;
  scan_status_t         status_r;
  logic [KeyIndexW-1:0] index_r;

  // The result register is free when empty or when its item leaves now.
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rows_r <= in_ch.row_lines;
      s1_cols_r <= in_ch.column_lines;
    end
  end

  // Decode of the registered scan.
  scan_result_t scan;

  kpd_scan_decode u_decode (
    .rows   (s1_rows_r),
    .cols   (s1_cols_r),
    .result (scan)
  );

  // Key-code lookup: bit 3 of the index picks the word, the low bits the byte.
  logic [MapWordW-1:0] map_word;
  logic [KeyCodeW-1:0] map_code;

  assign map_word = scan.index[KeyIndexW-1] ? key_map_high_r : key_map_low_r;
  assign map_code = map_word[scan.index[KeyIndexW-2:0]*KeyCodeW +: KeyCodeW];

  // Debounce state machine.
  deb_state_t          deb_state_r;
  deb_state_t          deb_state_nxt;
  logic [KeyCodeW-1:0] latched_key_r;
  logic [KeyCodeW-1:0] latched_key_nxt;
  logic                latch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_state_r   <= ST_RELEASED;
      latched_key_r <= '0;
    end else if (s1_advance) begin
      deb_state_r   <= deb_state_nxt;
      latched_key_r <= latched_key_nxt;
    end
  end

  always_comb begin
    deb_state_nxt = deb_state_r;
    latch         = 1'b0;
    unique case (scan.status)
      SCAN_VALID: begin
        unique case (deb_state_r)
          ST_RELEASED:       deb_state_nxt = ST_MAYBE_PUSHED;
          ST_MAYBE_PUSHED: begin
            deb_state_nxt = ST_PUSHED;
            latch         = 1'b1;
          end
          ST_PUSHED:         deb_state_nxt = ST_PUSHED;
          ST_MAYBE_RELEASED: deb_state_nxt = ST_PUSHED;
          default:           deb_state_nxt = ST_RELEASED;
        endcase
      end
      SCAN_NONE: begin
        if (deb_state_r == ST_PUSHED) begin
          deb_state_nxt = ST_MAYBE_RELEASED;
        end else begin
          deb_state_nxt = ST_RELEASED;
        end
      end
      // An invalid pattern leaves the machine where it is.
      default: deb_state_nxt = deb_state_r;
    endcase
    latched_key_nxt = latch ? map_code : latched_key_r;
  end

  // Result register: loads whenever a scan advances, so a stalled item holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      held_key_r <= latched_key_nxt;
      new_key_r  <= latch;
      status_r   <= scan.status;
      index_r    <= scan.index;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.held_key    = held_key_r;
  assign out_ch.new_key     = new_key_r;
  assign out_ch.scan_status = status_r;
  assign out_ch.raw_index   = index_r;

endmodule

>>> sv/kpd_scan_decode.sv
// Decodes one row/column scan into a status and a key index.
module kpd_scan_decode import kpd_pkg::*; (
  input  logic [NibbleW-1:0] rows,
  input  logic [NibbleW-1:0] cols,
  output scan_result_t       result
);

  // Finds the single low line of a nibble; ok is clear unless exactly one is low.
  function automatic logic [2:0] single_low(input logic [NibbleW-1:0] nib);
    logic [2:0] res;
    unique case (nib)
      4'b1110: res = 3'b100;
      4'b1101: res = 3'b101;
      4'b1011: res = 3'b110;
      4'b0111: res = 3'b111;
      default: res = 3'b000;
    endcase
    return res;
  endfunction

  logic [2:0] row_hit;
  logic [2:0] col_hit;

  assign row_hit = single_low(rows);
  assign col_hit = single_low(cols);

  always_comb begin
    result.index = '0;
    if (rows == '1) begin
      result.status = SCAN_NONE;
    end else if (row_hit[2] && col_hit[2]) begin
      result.status = SCAN_VALID;
      result.index  = {row_hit[1:0], col_hit[1:0]};
    end else begin
      result.status = SCAN_INVALID;
    end
  end

endmodule

>>> sim/tb_matrix_keypad_decode_debounce.sv
// Self-checking testbench for the 4x4 keypad scan decoder with debounce and key-code map.
module tb_matrix_keypad_decode_debounce;
  import kpd_pkg::*;

  // Cycles without any handshake on either channel before the run is declared hung.
  localparam int WatchdogLimit = 1000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int TailCycles    = 4;
  // Cycles left after a drain before the key map is rewritten.
  localparam int SettleCycles  = 2;
  localparam int MaxGap        = 14;
  localparam int MaxPrinted    = 40;
  localparam int RandomPhases  = 6;
  localparam int PhaseItems    = 158;

  localparam logic [NibbleW-1:0] NoKeyRows = 4'hF;

  // One expected result item, in the order of the result channel fields.
  typedef struct packed {
    logic [KeyCodeW-1:0]  held;
    logic                 new_key;
    scan_status_t         status;
    logic [KeyIndexW-1:0] index;
  } scan_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [MapWordW-1:0] cfg_wdata;

  kpd_in_if  in_ch ();
  kpd_out_if out_ch ();

  matrix_keypad_decode_debounce dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: our own copy of the debounce machine, the latched code and the map.
  deb_state_t          deb_state;
  logic [KeyCodeW-1:0] held_code;
  logic [MapWordW-1:0] map_low;
  logic [MapWordW-1:0] map_high;

  // Results predicted for accepted scans, oldest first.
  scan_report_t scan_reports_due[$];

  // Idle controls, changed per test phase. When off, that side never idles.
  bit in_gaps_on;
  bit out_stalls_on;

  int error_count;
  int scans_sent;
  int results_seen;
  int keys_latched;
  int map_writes;
  int stall_cycles;

  // Position of the single low bit of a nibble, or -1 when there is not exactly one.
  function automatic int zero_position(input logic [NibbleW-1:0] nib);
    case (nib)
      4'hE:    return 0;
      4'hD:    return 1;
      4'hB:    return 2;
      4'h7:    return 3;
      default: return -1;
    endcase
  endfunction

  // Decodes one scan, advances the debounce machine and returns the result item it causes.
  function automatic scan_report_t debounce_scan(input logic [NibbleW-1:0] rows,
                                                 input logic [NibbleW-1:0] cols);
    scan_report_t r;
    int rp;
    int cp;
    logic [MapWordW-1:0] word;
    r.new_key = 1'b0;
    r.index   = '0;
    rp = zero_position(rows);
    cp = zero_position(cols);
    // With all rows high the column nibble plays no part.
    if (rows == NoKeyRows) begin
      r.status = SCAN_NONE;
    end else if (rp >= 0 && cp >= 0) begin
      r.status = SCAN_VALID;
      r.index  = 4'(rp * 4 + cp);
    end else begin
      r.status = SCAN_INVALID;
    end
    case (r.status)
      SCAN_VALID: begin
        case (deb_state)
          ST_RELEASED: begin
            deb_state = ST_MAYBE_PUSHED;
          end
          ST_MAYBE_PUSHED: begin
            // Second valid scan in a row from the released side: latch the mapped code,
            // whatever its value is.
            deb_state = ST_PUSHED;
            word      = r.index[3] ? map_high : map_low;
            held_code = word[r.index[2:0]*8 +: 8];
            r.new_key = 1'b1;
            keys_latched++;
          end
          default: begin
            // Held key, or a bounce during release: back to pushed without a latch.
            deb_state = ST_PUSHED;
          end
        endcase
      end
      SCAN_NONE: begin
        if (deb_state == ST_PUSHED) begin
          deb_state = ST_MAYBE_RELEASED;
        end else begin
          deb_state = ST_RELEASED;
        end
      end
      default: begin
        // An invalid pattern leaves the machine and the latched code alone.
      end
    endcase
    r.held = held_code;
    return r;
  endfunction

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                              results_seen, name, got, want));
    end
  endtask

  // Offers one scan item after a random gap and waits until the block takes it.
  // Valid is left high on return so that a back-to-back item needs no second write
  // of valid in the same step; the drain task lowers it.
  task automatic send_scan(input logic [NibbleW-1:0] rows, input logic [NibbleW-1:0] cols);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.row_lines    <= rows;
    in_ch.column_lines <= cols;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_reports_due.push_back(debounce_scan(rows, cols));
    scans_sent++;
  endtask

  // A clean scan of one key: its row line and its column line low.
  task automatic send_key(input logic [3:0] key);
    send_scan(~(4'b0001 << key[3:2]), ~(4'b0001 << key[1:0]));
  endtask

  // Stops offering items and waits until every predicted result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (scan_reports_due.size() != 0) @(posedge clk);
  endtask

  // Rewrites both map words while the block is idle; the predictor follows at the same edge.
  task automatic write_key_maps(input logic [MapWordW-1:0] low_word,
                                input logic [MapWordW-1:0] high_word);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CfgKeyMapLow;
    cfg_wdata <= low_word;
    @(posedge clk);
    map_low    = low_word;
    cfg_index <= CfgKeyMapHigh;
    cfg_wdata <= high_word;
    @(posedge clk);
    map_high  = high_word;
    cfg_we   <= 1'b0;
    map_writes += 2;
  endtask

  // Right after reset the map is all zeros, so the first latched key reads code zero.
  // Also covers the all-low and all-high column nibbles with no row pressed and key 0.
  task automatic test_reset_state();
    send_scan(NoKeyRows, 4'h0);
    send_key(4'd0);
    send_key(4'd0);
    send_scan(NoKeyRows, 4'hF);
  endtask

  // Walks the full press, hold and release cycle, including a bounce while releasing.
  // Key 5 maps to 0xFF and key 15 to 0x0F, the highest key index.
  task automatic test_press_hold_release();
    write_key_maps(64'h0706FF0403020100, 64'h0F0E0D0CFE0A0908);
    send_scan(NoKeyRows, 4'hF);
    send_key(4'd5);
    send_key(4'd5);
    send_key(4'd5);
    send_scan(NoKeyRows, 4'h5);
    send_key(4'd5);
    send_scan(NoKeyRows, 4'hA);
    send_scan(NoKeyRows, 4'hF);
    send_key(4'd15);
    send_key(4'd15);
  endtask

  // A press bounce returns to released; invalid patterns in the maybe-pushed, pushed and
  // maybe-released states leave the machine where it is. Key 11 maps to 0xFE.
  task automatic test_bounce_and_invalid();
    send_scan(NoKeyRows, 4'h0);
    send_scan(NoKeyRows, 4'h0);
    send_key(4'd11);
    send_scan(NoKeyRows, 4'h3);
    send_key(4'd11);
    send_scan(4'h0, 4'hE);
    send_scan(4'hE, 4'hF);
    send_key(4'd11);
    send_scan(4'hE, 4'h0);
    send_scan(NoKeyRows, 4'hC);
    send_scan(4'hC, 4'h7);
    send_scan(NoKeyRows, 4'h7);
  endtask

  // Mostly realistic key activity with random content, plus noise and broken patterns.
  task automatic send_random_items(input int count);
    int first;
    int kind;
    int presses;
    logic [3:0] key;
    first = scans_sent;
    while (scans_sent - first < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // A press of one to four valid scans, with the odd chatter gap, then a release.
        key     = 4'($urandom_range(0, 15));
        presses = $urandom_range(1, 4);
        for (int i = 0; i < presses; i++) begin
          send_key(key);
          if ($urandom_range(0, 5) == 0) begin
            send_scan(NoKeyRows, 4'($urandom));
          end
        end
        repeat ($urandom_range(1, 3)) send_scan(NoKeyRows, 4'($urandom));
      end else if (kind <= 7) begin
        send_scan(4'($urandom), 4'($urandom));
      end else if (kind == 8) begin
        // One row low, with the columns all low or random.
        send_scan(~(4'b0001 << $urandom_range(0, 3)),
                  ($urandom_range(0, 1) == 1) ? 4'h0 : 4'($urandom));
      end else begin
        send_scan(NoKeyRows, 4'($urandom));
      end
    end
  endtask

  // Several map settings (all zeros, all ones, random) and idle patterns, burst included.
  task automatic test_random_traffic();
    logic [MapWordW-1:0] low_word;
    logic [MapWordW-1:0] high_word;
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        low_word  = '0;
        high_word = '0;
      end else if (p == 1) begin
        low_word  = '1;
        high_word = '1;
      end else begin
        low_word  = {$urandom, $urandom};
        high_word = {$urandom, $urandom};
      end
      write_key_maps(low_word, high_word);
      in_gaps_on    = (p == 1) ? 1'b1 : (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      out_stalls_on = (p == 1) ? 1'b1 : (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      send_random_items(PhaseItems);
    end
  endtask

  // Result sink: for every item it draws a stall, then holds ready high until a
  // result moves. The first write of ready happens at time zero, the loop starts
  // at the next edge so no step sees two writes.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Checks every accepted result item against the oldest prediction. Signals read right
  // after the edge still hold the values they had at the edge.
  always @(posedge clk) begin : check_results
    scan_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (scan_reports_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no scan waiting", results_seen));
      end else begin
        want = scan_reports_due.pop_front();
        compare_field("held_key", out_ch.held_key, want.held);
        compare_field("new_key", 8'(out_ch.new_key), 8'(want.new_key));
        compare_field("scan_status", 8'(out_ch.scan_status), 8'(want.status));
        compare_field("raw_index", 8'(out_ch.raw_index), 8'(want.index));
      end
      results_seen++;
    end
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
      $display("tb_matrix_keypad_decode_debounce: FAIL");
      $finish;
    end
  end

  initial begin
    // All inputs known from time zero; reset held low at the start, then released once.
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.row_lines    <= NoKeyRows;
    in_ch.column_lines <= NoKeyRows;
    cfg_we             <= 1'b0;
    cfg_index          <= CfgKeyMapLow;
    cfg_wdata          <= '0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    error_count   = 0;
    scans_sent    = 0;
    results_seen  = 0;
    keys_latched  = 0;
    map_writes    = 0;
    stall_cycles  = 0;
    deb_state     = ST_RELEASED;
    held_code     = '0;
    map_low       = '0;
    map_high      = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_press_hold_release();
    test_bounce_and_invalid();
    test_random_traffic();

    drain_results();
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d scan items and checked %0d result items; %0d keys were latched.",
             scans_sent, results_seen, keys_latched);
    $display("The key map was written %0d times, with all-zero, all-one and random words.",
             map_writes);
    if (error_count == 0) begin
      $display("tb_matrix_keypad_decode_debounce: PASS");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("tb_matrix_keypad_decode_debounce: FAIL");
    end
    $finish;
  end

endmodule
